// ----- hw/rtl/tsnw_pkg.sv -----
// Shared types, constants and coordinate functions of the texture sampler.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none
package tsnw_pkg;

	localparam int TEXEL_WORDS = 65536;
	localparam int TEXEL_AW    = 16;
	localparam int TEXEL_DW    = 32;
	localparam int MAX_SIDE    = 256;
	localparam int SIDE_W      = 9;
	localparam int COORD_W     = 17;
	localparam int TEXCRD_W    = 8;
	localparam int PADDR_W     = 3;

	localparam logic [COORD_W-1:0] FIX_ONE  = 17'h10000;
	localparam logic [24:0]        FIX_HALF = 25'h0008000;

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	localparam logic REG_TEX_WIDTH  = 1'b0;
	localparam logic REG_TEX_HEIGHT = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_WRITE = 5'b00010,
		ST_SCALE = 5'b00100,
		ST_FETCH = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	typedef struct packed {
		logic capture;
		logic wr_en;
		logic scale_en;
		logic rd_en;
	} dp_cmd_t;

	typedef struct packed {
		logic             we;
		logic             sel;
		logic [SIDE_W-1:0] data;
	} cfg_wr_t;

	// Wraps a signed Q15.16 coordinate into the range 0 to 1 inclusive.
	function automatic logic [COORD_W-1:0] wrap_coord(input logic [31:0] raw);
		logic [31:0] neg_raw;
		logic [COORD_W-1:0] res;
		neg_raw = 32'd0 - raw;
		if (raw[31]) begin
			res = FIX_ONE - {1'b0, neg_raw[15:0]};
		end else if (raw > {15'd0, FIX_ONE}) begin
			res = {1'b0, raw[15:0]};
		end else begin
			res = raw[COORD_W-1:0];
		end
		return res;
	endfunction

	// Clamps a side register to the range 1 to MAX_SIDE.
	function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] side);
		logic [SIDE_W-1:0] res;
		if (side == '0) begin
			res = SIDE_W'(1);
		end else if (side > SIDE_W'(MAX_SIDE)) begin
			res = SIDE_W'(MAX_SIDE);
		end else begin
			res = side;
		end
		return res;
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/tsnw_ram.sv -----
// Generic memory with one write port and one registered read port.
// Stands alone; depends on no package.
`default_nettype none
module tsnw_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/tsnw_ctrl.sv -----
// Controller state machine of the texture sampler.
// Drives the datapath commands; depends on tsnw_pkg.
`default_nettype none
module tsnw_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic             cmd,
	output logic                  busy,
	output logic                  done,
	output tsnw_pkg::dp_cmd_t     dp_cmd
);

	tsnw_pkg::state_t state_q;
	tsnw_pkg::state_t state_d;
	logic accept;

	assign accept = start && (state_q == tsnw_pkg::ST_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			tsnw_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (cmd == tsnw_pkg::CMD_SAMPLE) ? tsnw_pkg::ST_SCALE
					                                        : tsnw_pkg::ST_WRITE;
				end
			end
			tsnw_pkg::ST_WRITE: state_d = tsnw_pkg::ST_IDLE;
			tsnw_pkg::ST_SCALE: state_d = tsnw_pkg::ST_FETCH;
			tsnw_pkg::ST_FETCH: state_d = tsnw_pkg::ST_OUT;
			tsnw_pkg::ST_OUT:   state_d = tsnw_pkg::ST_IDLE;
			default:            state_d = tsnw_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsnw_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy             = (state_q != tsnw_pkg::ST_IDLE);
	assign done             = (state_q == tsnw_pkg::ST_OUT);
	assign dp_cmd.capture   = accept;
	assign dp_cmd.wr_en     = (state_q == tsnw_pkg::ST_WRITE);
	assign dp_cmd.scale_en  = (state_q == tsnw_pkg::ST_SCALE);
	assign dp_cmd.rd_en     = (state_q == tsnw_pkg::ST_FETCH);

`ifndef SYNTHESIS
	a_scale_to_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.scale_en |=> dp_cmd.rd_en)
		else $error("Scale step not followed by the memory fetch.");
	a_fetch_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.rd_en |=> done)
		else $error("Memory fetch not followed by the result strobe.");
	a_no_mem_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(dp_cmd.wr_en && dp_cmd.rd_en))
		else $error("Memory written and read in the same cycle.");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/tsnw_dp.sv -----
// Datapath of the texture sampler: size registers, coordinate wrap and scale,
// texel index and texel memory. Depends on tsnw_pkg and tsnw_ram.
`default_nettype none
module tsnw_dp (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire tsnw_pkg::dp_cmd_t                  dp_cmd,
	input  wire tsnw_pkg::cfg_wr_t                  cfg_wr,
	input  wire logic [tsnw_pkg::TEXEL_AW-1:0]      texel_addr,
	input  wire logic [tsnw_pkg::TEXEL_DW-1:0]      texel_rgba,
	input  wire logic signed [31:0]                 coord_u,
	input  wire logic signed [31:0]                 coord_v,
	output logic      [tsnw_pkg::SIDE_W-1:0]        tex_width,
	output logic      [tsnw_pkg::SIDE_W-1:0]        tex_height,
	output logic      [tsnw_pkg::TEXEL_DW-1:0]      texel
);

	logic [tsnw_pkg::SIDE_W-1:0]   width_q;
	logic [tsnw_pkg::SIDE_W-1:0]   height_q;
	logic [tsnw_pkg::TEXEL_AW-1:0] waddr_q;
	logic [tsnw_pkg::TEXEL_DW-1:0] wdata_q;
	logic [31:0]                   u_q;
	logic [31:0]                   v_q;
	logic [tsnw_pkg::TEXCRD_W-1:0] x_q;
	logic [tsnw_pkg::TEXCRD_W-1:0] y_q;

	logic [tsnw_pkg::SIDE_W-1:0]   w_eff;
	logic [tsnw_pkg::SIDE_W-1:0]   h_eff;
	logic [tsnw_pkg::SIDE_W-1:0]   w_m1;
	logic [tsnw_pkg::SIDE_W-1:0]   h_m1;
	logic [tsnw_pkg::COORD_W-1:0]  u_wrap;
	logic [tsnw_pkg::COORD_W-1:0]  v_wrap;
	logic [24:0]                   x_prod;
	logic [24:0]                   y_prod;
	logic [16:0]                   idx_full;
	logic [tsnw_pkg::TEXEL_AW-1:0] raddr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= tsnw_pkg::SIDE_W'(1);
			height_q <= tsnw_pkg::SIDE_W'(1);
		end else if (cfg_wr.we) begin
			if (cfg_wr.sel == tsnw_pkg::REG_TEX_WIDTH) begin
				width_q <= cfg_wr.data;
			end else begin
				height_q <= cfg_wr.data;
			end
		end
	end

	assign w_eff  = tsnw_pkg::eff_side(width_q);
	assign h_eff  = tsnw_pkg::eff_side(height_q);
	assign w_m1   = w_eff - tsnw_pkg::SIDE_W'(1);
	assign h_m1   = h_eff - tsnw_pkg::SIDE_W'(1);
	assign u_wrap = tsnw_pkg::wrap_coord(u_q);
	assign v_wrap = tsnw_pkg::wrap_coord(v_q);

	assign x_prod = 25'(u_wrap) * 25'(w_m1[tsnw_pkg::TEXCRD_W-1:0]) + tsnw_pkg::FIX_HALF;
	assign y_prod = 25'(v_wrap) * 25'(h_m1[tsnw_pkg::TEXCRD_W-1:0]) + tsnw_pkg::FIX_HALF;

	always_ff @(posedge clk) begin
		if (dp_cmd.capture) begin
			waddr_q <= texel_addr;
			wdata_q <= texel_rgba;
			u_q     <= coord_u;
			v_q     <= coord_v;
		end
		if (dp_cmd.scale_en) begin
			x_q <= x_prod[23:16];
			y_q <= y_prod[23:16];
		end
	end

	assign idx_full = 17'(y_q) * 17'(w_eff) + 17'(x_q);
	assign raddr    = idx_full[tsnw_pkg::TEXEL_AW-1:0];

	tsnw_ram #(
		.WIDTH(tsnw_pkg::TEXEL_DW),
		.DEPTH(tsnw_pkg::TEXEL_WORDS)
	) u_texel_ram (
		.clk  (clk),
		.we   (dp_cmd.wr_en),
		.waddr(waddr_q),
		.wdata(wdata_q),
		.re   (dp_cmd.rd_en),
		.raddr(raddr),
		.rdata(texel)
	);

	assign tex_width  = width_q;
	assign tex_height = height_q;

endmodule
`default_nettype wire

// ----- hw/rtl/texture_sampler_nearest_wrap_unit.sv -----
// A sample is captured when accepted, then passes the scale step, which registers the texel
// coordinates, the index step, which forms the address from them, and the registered read of
// the texel memory; done marks the result. While busy, the block ignores start. Results are
// strobed for one cycle and cannot be stalled.
// Reset is asynchronous and active low; it clears the controller and sets both sizes to 1.
// Texel memory contents are not reset.
// Top level of the texture sampler; depends on tsnw_pkg, tsnw_ctrl and tsnw_dp.
`default_nettype none
module texture_sampler_nearest_wrap_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic                           cmd,
	input  wire logic [15:0]                    texel_addr,
	input  wire logic [31:0]                    texel_rgba,
	input  wire logic signed [31:0]             coord_u,
	input  wire logic signed [31:0]             coord_v,
	output logic                                done,
	output logic      [7:0]                     red,
	output logic      [7:0]                     green,
	output logic      [7:0]                     blue,
	output logic      [7:0]                     alpha,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [tsnw_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [31:0]                    pwdata,
	output logic      [31:0]                    prdata,
	output logic                                pready
);

	tsnw_pkg::dp_cmd_t             dp_cmd;
	tsnw_pkg::cfg_wr_t             cfg_wr;
	logic [tsnw_pkg::SIDE_W-1:0]   tex_width;
	logic [tsnw_pkg::SIDE_W-1:0]   tex_height;
	logic [tsnw_pkg::TEXEL_DW-1:0] texel;

	assign pready      = 1'b1;
	assign cfg_wr.we   = psel && penable && pwrite;
	assign cfg_wr.sel  = paddr[2];
	assign cfg_wr.data = pwdata[tsnw_pkg::SIDE_W-1:0];

	always_comb begin
		case (paddr[2])
			tsnw_pkg::REG_TEX_WIDTH:  prdata = 32'(tex_width);
			tsnw_pkg::REG_TEX_HEIGHT: prdata = 32'(tex_height);
			default:                  prdata = '0;
		endcase
	end

	tsnw_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done),
		.dp_cmd(dp_cmd)
	);

	tsnw_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.dp_cmd    (dp_cmd),
		.cfg_wr    (cfg_wr),
		.texel_addr(texel_addr),
		.texel_rgba(texel_rgba),
		.coord_u   (coord_u),
		.coord_v   (coord_v),
		.tex_width (tex_width),
		.tex_height(tex_height),
		.texel     (texel)
	);

	assign red   = texel[7:0];
	assign green = texel[15:8];
	assign blue  = texel[23:16];
	assign alpha = texel[31:24];

`ifndef SYNTHESIS
	a_sample_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd) |-> ##3 done)
		else $error("Sample beat did not produce a result three cycles later.");
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !cmd) |-> ##3 !done)
		else $error("Texel write beat produced a result.");
	a_done_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("Block still busy after the result strobe.");
`endif

endmodule
`default_nettype wire
